### hw/rtl/mru_pkg.sv
// ----------------------------------------------------------------------------
// mru_pkg
// shared types and constants of the move-to-front recently-used list
// ----------------------------------------------------------------------------
package mru_pkg;

  localparam int unsigned ListDepthDefault = 16;
  localparam int unsigned IdWidthDefault   = 32;
  localparam int unsigned ItemIdW          = 32;
  localparam int unsigned PosW             = 4;

  typedef enum logic [1:0] {
    OP_TOUCH  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [ItemIdW-1:0] item_id;
  } in_t;

  typedef struct packed {
    logic            was_present;
    logic [PosW-1:0] hit_position;
  } out_t;

  // per-transaction update strobes broadcast to every cell
  typedef struct packed {
    logic touch_en;
    logic remove_en;
  } cell_ctrl_t;

endpackage

### hw/rtl/mru_move_to_front_list_core.sv
// ----------------------------------------------------------------------------
// mru_move_to_front_list_core
// most-recently-used identifier list with move-to-front update
// ----------------------------------------------------------------------------
// usage
//   in channel  : in_valid_i / in_ready_o carry an operation (touch, remove,
//                 check; the unused code acts as a check) and an identifier
//   out channel : out_valid_o / out_ready_i carry one result per input
//                 transaction: was_present and the lowest matching slot
//   latency     : the result is valid the cycle after the input transaction
//   throughput  : one transaction per cycle; the row of slot cells compares
//                 and shifts in the same cycle, and the single output
//                 register takes a new result whenever it is empty or being
//                 drained
//   stall       : while out_ready_i is low with a result pending, in_ready_o
//                 drops and the list holds its contents
//   reset       : rst_ni clears every slot to zero and empties the output
//                 register; an empty slot holds zero so identifier zero
//                 matches it
// ----------------------------------------------------------------------------
module mru_move_to_front_list_core #(
  parameter int unsigned LIST_DEPTH = mru_pkg::ListDepthDefault,
  parameter int unsigned ID_WIDTH   = mru_pkg::IdWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mru_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mru_pkg::out_t out_data_o
);

  // handshake: the output register parts the two sides
  logic                out_valid_q;
  mru_pkg::out_t       out_q;
  logic                in_accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // key is the identifier at the list's width
  logic [ID_WIDTH-1:0] key;
  assign key = ID_WIDTH'(in_data_i.item_id);

  // operation decode into broadcast strobes
  mru_pkg::cell_ctrl_t ctrl;

  always_comb begin
    ctrl = '0;
    unique case (in_data_i.operation)
      mru_pkg::OP_TOUCH:  ctrl.touch_en  = in_accept;
      mru_pkg::OP_REMOVE: ctrl.remove_en = in_accept;
      default:            ctrl = '0; // check and the unused code
    endcase
  end

  // chain wiring: slot k takes left from k-1 on a touch and right from
  // k+1 on a remove; hit and position ripple from the front slot
  logic [ID_WIDTH-1:0]      ids   [LIST_DEPTH];
  logic [LIST_DEPTH:0]      hit_chain;
  logic [mru_pkg::PosW-1:0] pos_chain [LIST_DEPTH+1];

  assign hit_chain[0] = 1'b0;
  assign pos_chain[0] = '0;

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    logic [ID_WIDTH-1:0] left_id;
    logic [ID_WIDTH-1:0] right_id;

    // front slot receives the key, last slot is refilled with zero
    if (k == 0) begin : g_front
      assign left_id = key;
    end else begin : g_mid_left
      assign left_id = ids[k-1];
    end
    if (k == LIST_DEPTH - 1) begin : g_back
      assign right_id = '0;
    end else begin : g_mid_right
      assign right_id = ids[k+1];
    end

    mru_cell #(
      .IdWidth (ID_WIDTH),
      .CellIdx (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .key_i      (key),
      .ctrl_i     (ctrl),
      .left_id_i  (left_id),
      .right_id_i (right_id),
      .prev_hit_i (hit_chain[k]),
      .prev_pos_i (pos_chain[k]),
      .id_o       (ids[k]),
      .hit_o      (hit_chain[k+1]),
      .pos_o      (pos_chain[k+1])
    );
  end

  // result register
  mru_pkg::out_t out_d;
  logic          out_valid_d;

  always_comb begin
    out_d              = out_q;
    out_valid_d        = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_accept) begin
      out_d.was_present  = hit_chain[LIST_DEPTH];
      out_d.hit_position = pos_chain[LIST_DEPTH];
      out_valid_d        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/mru_cell.sv
// ----------------------------------------------------------------------------
// mru_cell
// one list slot: holds an identifier, compares it with the key and moves
// it toward either neighbor on a touch or a remove
// ----------------------------------------------------------------------------
module mru_cell #(
  parameter int unsigned IdWidth = mru_pkg::IdWidthDefault,
  parameter int unsigned CellIdx = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [IdWidth-1:0]        key_i,
  input  mru_pkg::cell_ctrl_t       ctrl_i,
  input  logic [IdWidth-1:0]        left_id_i,
  input  logic [IdWidth-1:0]        right_id_i,
  input  logic                      prev_hit_i,
  input  logic [mru_pkg::PosW-1:0]  prev_pos_i,
  output logic [IdWidth-1:0]        id_o,
  output logic                      hit_o,
  output logic [mru_pkg::PosW-1:0]  pos_o
);

  logic [IdWidth-1:0] id_d, id_q;
  logic               match;

  assign match = (id_q == key_i);
  assign hit_o = prev_hit_i | match;
  // first match along the chain wins
  assign pos_o = prev_hit_i ? prev_pos_i
               : (match ? mru_pkg::PosW'(CellIdx) : '0);
  assign id_o  = id_q;

  always_comb begin
    id_d = id_q;
    if (ctrl_i.touch_en && !prev_hit_i) begin
      id_d = left_id_i;
    end else if (ctrl_i.remove_en && hit_o) begin
      id_d = right_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q <= '0;
    end else begin
      id_q <= id_d;
    end
  end

endmodule
